// File: sv/height_to_color_ramp_assert.svh
// ----------------------------------------------------------------------------
// height_to_color_ramp_assert.svh
// Assertion macros shared by the color ramp checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_COLOR_RAMP_ASSERT_SVH
`define HEIGHT_TO_COLOR_RAMP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define HCR_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define HCR_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Types and constants of the three-stop height to color ramp.
// ----------------------------------------------------------------------------
package hcr_pkg;

	// height sample and register widths
	localparam int HEIGHT_W = 32;
	localparam int COLOR_W  = 8;
	localparam int RGB_W    = 3 * COLOR_W;
	localparam int INDEX_W  = 3;

	// interpolation datapath widths
	localparam int QUOT_W = COLOR_W;
	localparam int PROD_W = HEIGHT_W + COLOR_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int DEN_W  = HEIGHT_W + 1;

	// select, setup, multiply, numerator, one stage per quotient bit, final add
	localparam int NUM_STAGES = 5 + QUOT_W;

	// reset colors: red 7:0, green 15:8, blue 23:16
	localparam logic [RGB_W-1:0] LOW_COLOR_RST  = 24'h6FA55F;
	localparam logic [RGB_W-1:0] MID_COLOR_RST  = 24'hBEF0FA;
	localparam logic [RGB_W-1:0] HIGH_COLOR_RST = 24'h81B6FE;

	// configuration register indexes
	typedef enum logic [INDEX_W-1:0] {
		REG_LOW_HEIGHT  = 3'd0,
		REG_MID_HEIGHT  = 3'd1,
		REG_HIGH_HEIGHT = 3'd2,
		REG_LOW_COLOR   = 3'd3,
		REG_MID_COLOR   = 3'd4,
		REG_HIGH_COLOR  = 3'd5
	} cfg_reg_t;

	// region a height falls in
	typedef enum logic [1:0] {
		REGION_BELOW = 2'd0,
		REGION_LOWER = 2'd1,
		REGION_UPPER = 2'd2,
		REGION_ABOVE = 2'd3
	} region_t;

endpackage

// File: sv/hcr_select.sv
// ----------------------------------------------------------------------------
// hcr_select
// First stage: classifies a height against the three stops and forms the
// offset into and the span of the ramp it falls on.
// ----------------------------------------------------------------------------
module hcr_select (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [hcr_pkg::HEIGHT_W-1:0] height,
	input  logic signed [hcr_pkg::HEIGHT_W-1:0] low_height,
	input  logic signed [hcr_pkg::HEIGHT_W-1:0] mid_height,
	input  logic signed [hcr_pkg::HEIGHT_W-1:0] high_height,
	output hcr_pkg::region_t                    region_s1,
	output logic        [hcr_pkg::HEIGHT_W-1:0] off_s1,
	output logic        [hcr_pkg::HEIGHT_W-1:0] span_s1
);

	localparam int H = hcr_pkg::HEIGHT_W;

	logic [H-1:0] h_key, lo_key, mi_key, hi_key;
	hcr_pkg::region_t region_d;
	logic [H-1:0] off_d, span_d;

	// offset-binary keys compare in signed order
	assign h_key  = {~height[H-1], height[H-2:0]};
	assign lo_key = {~low_height[H-1], low_height[H-2:0]};
	assign mi_key = {~mid_height[H-1], mid_height[H-2:0]};
	assign hi_key = {~high_height[H-1], high_height[H-2:0]};

	// region tests in fixed priority, then offset and span of the ramp
	always_comb begin
		off_d  = '0;
		span_d = '0;
		if (h_key < lo_key) begin
			region_d = hcr_pkg::REGION_BELOW;
		end else if (h_key > hi_key) begin
			region_d = hcr_pkg::REGION_ABOVE;
		end else if (h_key < mi_key) begin
			region_d = hcr_pkg::REGION_LOWER;
			off_d    = $unsigned(height - low_height);
			span_d   = $unsigned(mid_height - low_height);
		end else begin
			region_d = hcr_pkg::REGION_UPPER;
			off_d    = $unsigned(height - mid_height);
			span_d   = $unsigned(high_height - mid_height);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s1 <= region_d;
			off_s1    <= off_d;
			span_s1   <= span_d;
		end
	end

endmodule

// File: sv/hcr_chan.sv
// ----------------------------------------------------------------------------
// hcr_chan
// One color channel: start/end selection, scale multiply, and a pipelined
// restoring divider giving floor((2*m*o + s) / (2*s)), one quotient bit a stage.
// ----------------------------------------------------------------------------
module hcr_chan (
	input  logic                                 clk,
	input  logic [hcr_pkg::NUM_STAGES:2]         en,
	input  hcr_pkg::region_t                     region_s1,
	input  logic [hcr_pkg::HEIGHT_W-1:0]         off_s1,
	input  logic [hcr_pkg::HEIGHT_W-1:0]         span_s1,
	input  logic [hcr_pkg::COLOR_W-1:0]          lo_c,
	input  logic [hcr_pkg::COLOR_W-1:0]          mi_c,
	input  logic [hcr_pkg::COLOR_W-1:0]          hi_c,
	output logic [hcr_pkg::COLOR_W-1:0]          val_s13
);

	localparam int H  = hcr_pkg::HEIGHT_W;
	localparam int C  = hcr_pkg::COLOR_W;
	localparam int QW = hcr_pkg::QUOT_W;
	localparam int PW = hcr_pkg::PROD_W;
	localparam int NW = hcr_pkg::NUM_W;
	localparam int DW = hcr_pkg::DEN_W;
	localparam int NS = hcr_pkg::NUM_STAGES;

	logic [C-1:0] c0, c1, base_d, mag_d;
	logic [H-1:0] off_d, span_d;

	logic [C-1:0]  base_s2, mag_s2;
	logic [H-1:0]  off_s2, span_s2;
	logic [PW-1:0] prod_s3;
	logic [C-1:0]  base_s3;
	logic [H-1:0]  span_s3;

	// divider pipe: element j is the state entering quotient step j
	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quot_s [QW+1];
	logic [C-1:0]  base_s [QW+1];

	logic [C:0] sum;

	// ramp endpoints
	always_comb begin
		case (region_s1)
			hcr_pkg::REGION_LOWER: begin
				c0 = lo_c;
				c1 = mi_c;
			end
			default: begin
				c0 = mi_c;
				c1 = hi_c;
			end
		endcase
	end

	// setup: flat colors become m = 0 over a unit span, so the quotient is zero
	always_comb begin
		base_d = c0;
		mag_d  = '0;
		off_d  = '0;
		span_d = H'(1);
		if (region_s1 == hcr_pkg::REGION_BELOW) begin
			base_d = lo_c;
		end else if (region_s1 == hcr_pkg::REGION_ABOVE) begin
			base_d = hi_c;
		end else if (span_s1 != '0) begin
			span_d = span_s1;
			if (c1 >= c0) begin
				base_d = c0;
				mag_d  = c1 - c0;
				off_d  = off_s1;
			end else begin
				base_d = c1;
				mag_d  = c0 - c1;
				off_d  = span_s1 - off_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			base_s2 <= base_d;
			mag_s2  <= mag_d;
			off_s2  <= off_d;
			span_s2 <= span_d;
		end
	end

	// scale multiply
	always_ff @(posedge clk) begin
		if (en[3]) begin
			prod_s3 <= PW'(mag_s2) * PW'(off_s2);
			base_s3 <= base_s2;
			span_s3 <= span_s2;
		end
	end

	// numerator 2*m*o + s and divisor 2*s
	always_ff @(posedge clk) begin
		if (en[4]) begin
			rem_s[0]  <= {1'b0, prod_s3, 1'b0} + NW'(span_s3);
			den_s[0]  <= {span_s3, 1'b0};
			quot_s[0] <= '0;
			base_s[0] <= base_s3;
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int SH = QW - 1 - j;
		logic [NW-1:0] trial;
		logic          take;

		assign trial = NW'(den_s[j]) << SH;
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk) begin
			if (en[5 + j]) begin
				quot_s[j+1] <= {quot_s[j][QW-2:0], take};
				base_s[j+1] <= base_s[j];
			end
		end

		if (j < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[5 + j]) begin
					rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	// final add with saturation
	assign sum = {1'b0, base_s[QW]} + {1'b0, quot_s[QW]};

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			val_s13 <= sum[C] ? {C{1'b1}} : sum[C-1:0];
		end
	end

endmodule

// File: sv/height_to_color_ramp.sv
// ----------------------------------------------------------------------------
// height_to_color_ramp
// Maps signed Q24.8 height samples to RGB through a three-stop linear ramp.
//
// channel  dir  handshake                  payload
// height   in   height_valid/height_ready  height[31:0] signed
// pix      out  pix_valid/pix_ready        red, green, blue [7:0], region [1:0]
// cfg      in   cfg_valid/cfg_ready        cfg_index[2:0], cfg_data[31:0]
//
// One item per cycle sustained while pix_ready is high; the path is select,
// setup, multiply, numerator, eight one-bit restoring divide stages, final add.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and the input stays ready until every stage holds an item.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module height_to_color_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                height_valid,
	output logic                                height_ready,
	input  logic signed [hcr_pkg::HEIGHT_W-1:0] height,
	output logic                                pix_valid,
	input  logic                                pix_ready,
	output logic        [hcr_pkg::COLOR_W-1:0]  red,
	output logic        [hcr_pkg::COLOR_W-1:0]  green,
	output logic        [hcr_pkg::COLOR_W-1:0]  blue,
	output logic        [1:0]                   region,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [hcr_pkg::INDEX_W-1:0]  cfg_index,
	input  logic        [hcr_pkg::HEIGHT_W-1:0] cfg_data
);

	localparam int H  = hcr_pkg::HEIGHT_W;
	localparam int C  = hcr_pkg::COLOR_W;
	localparam int RW = hcr_pkg::RGB_W;
	localparam int NS = hcr_pkg::NUM_STAGES;

	logic signed [H-1:0] low_height_q, mid_height_q, high_height_q;
	logic [RW-1:0]       low_color_q, mid_color_q, high_color_q;

	logic [NS:1] vld_s;
	logic [NS:1] en;

	hcr_pkg::region_t region_s1;
	hcr_pkg::region_t region_s [NS:2];
	logic [H-1:0]     off_s1, span_s1;
	logic [C-1:0]     chan_val [3];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_height_q  <= '0;
			mid_height_q  <= '0;
			high_height_q <= '0;
			low_color_q   <= hcr_pkg::LOW_COLOR_RST;
			mid_color_q   <= hcr_pkg::MID_COLOR_RST;
			high_color_q  <= hcr_pkg::HIGH_COLOR_RST;
		end else if (cfg_valid) begin
			unique case (hcr_pkg::cfg_reg_t'(cfg_index))
				hcr_pkg::REG_LOW_HEIGHT:  low_height_q  <= cfg_data;
				hcr_pkg::REG_MID_HEIGHT:  mid_height_q  <= cfg_data;
				hcr_pkg::REG_HIGH_HEIGHT: high_height_q <= cfg_data;
				hcr_pkg::REG_LOW_COLOR:   low_color_q   <= cfg_data[RW-1:0];
				hcr_pkg::REG_MID_COLOR:   mid_color_q   <= cfg_data[RW-1:0];
				hcr_pkg::REG_HIGH_COLOR:  high_color_q  <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// per-stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		en[NS] = !vld_s[NS] || pix_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign height_ready = en[1];

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= height_valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// region rides alongside the channel pipes
	always_ff @(posedge clk) begin
		if (en[2]) region_s[2] <= region_s1;
		for (int k = 3; k <= NS; k++) begin
			if (en[k]) region_s[k] <= region_s[k-1];
		end
	end

	hcr_select u_select (
		.clk         (clk),
		.en          (en[1]),
		.height      (height),
		.low_height  (low_height_q),
		.mid_height  (mid_height_q),
		.high_height (high_height_q),
		.region_s1   (region_s1),
		.off_s1      (off_s1),
		.span_s1     (span_s1)
	);

	// one divider pipe per color channel
	for (genvar k = 0; k < 3; k++) begin : g_chan
		hcr_chan u_chan (
			.clk       (clk),
			.en        (en[NS:2]),
			.region_s1 (region_s1),
			.off_s1    (off_s1),
			.span_s1   (span_s1),
			.lo_c      (low_color_q[C*k +: C]),
			.mi_c      (mid_color_q[C*k +: C]),
			.hi_c      (high_color_q[C*k +: C]),
			.val_s13   (chan_val[k])
		);
	end

	// output
	assign pix_valid = vld_s[NS];
	assign red       = chan_val[0];
	assign green     = chan_val[1];
	assign blue      = chan_val[2];
	assign region    = region_s[NS];

endmodule

// File: sv/hcr_check.sv
// ----------------------------------------------------------------------------
// hcr_check
// Port-level checks for the color ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "height_to_color_ramp_assert.svh"

module hcr_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               height_ready,
	input logic                               pix_valid,
	input logic                               pix_ready,
	input logic [hcr_pkg::COLOR_W-1:0]        red,
	input logic [hcr_pkg::COLOR_W-1:0]        green,
	input logic [hcr_pkg::COLOR_W-1:0]        blue,
	input logic [1:0]                         region,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [hcr_pkg::INDEX_W-1:0]        cfg_index,
	input logic [hcr_pkg::HEIGHT_W-1:0]       cfg_data
);

	localparam int RW = hcr_pkg::RGB_W;

	logic [RW-1:0] low_color_q, high_color_q;
	logic          cfg_wr;

	// shadow of the flat end colors
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_color_q  <= hcr_pkg::LOW_COLOR_RST;
			high_color_q <= hcr_pkg::HIGH_COLOR_RST;
		end else begin
			if (cfg_wr && cfg_index == hcr_pkg::REG_LOW_COLOR)
				low_color_q <= cfg_data[RW-1:0];
			if (cfg_wr && cfg_index == hcr_pkg::REG_HIGH_COLOR)
				high_color_q <= cfg_data[RW-1:0];
		end
	end

	// a stalled item holds its payload
	`HCR_AST_NEXT(a_out_hold, pix_valid && !pix_ready, pix_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(region), "stalled item changed")

	// an empty output stage means no stage can block the input
	`HCR_AST_NOW(a_ready_empty, !pix_valid, height_ready, "input blocked with empty output")

	// a draining output frees the whole pipe
	`HCR_AST_NOW(a_ready_drain, pix_ready, height_ready, "input blocked while output drains")

	// below the low stop the low color comes out unchanged
	`HCR_AST_NOW(a_below_color, pix_valid && region == hcr_pkg::REGION_BELOW, red == low_color_q[7:0] && green == low_color_q[15:8] && blue == low_color_q[23:16], "wrong color below low stop")

	// above the high stop the high color comes out unchanged
	`HCR_AST_NOW(a_above_color, pix_valid && region == hcr_pkg::REGION_ABOVE, red == high_color_q[7:0] && green == high_color_q[15:8] && blue == high_color_q[23:16], "wrong color above high stop")

endmodule

bind height_to_color_ramp hcr_check u_hcr_check (.*);
